[sv/cst_pkg.sv]
// ----------------------------------------------------------------------------
// cst_pkg: shared types and codes of the connection slot table
// Command and status codes, channel payloads and the structs that travel
// between the table top level and its slot cells.
// ----------------------------------------------------------------------------
package cst_pkg;

  // command codes
  localparam logic [3:0] CMD_ASSIGN       = 4'd0;
  localparam logic [3:0] CMD_RELEASE      = 4'd1;
  localparam logic [3:0] CMD_BUTTONS      = 4'd2;
  localparam logic [3:0] CMD_LEFT_STICK   = 4'd3;
  localparam logic [3:0] CMD_RIGHT_STICK  = 4'd4;
  localparam logic [3:0] CMD_DPAD         = 4'd5;
  localparam logic [3:0] CMD_BATTERY      = 4'd6;
  localparam logic [3:0] CMD_QUERY_HANDLE = 4'd7;
  localparam logic [3:0] CMD_QUERY_PLAYER = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // input item
  typedef struct packed {
    logic [3:0]         command;
    logic [15:0]        conn_handle;
    logic [31:0]        button_bits;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [7:0]         small_value;
    logic [1:0]         player_query;
  } cst_in_t;

  // result item
  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         player_number;
    logic [2:0]         active_count;
    logic [15:0]        found_handle;
    logic [31:0]        slot_buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         dpad_code;
    logic [7:0]         battery_level;
  } cst_out_t;

  // lookup request, sampled by every cell at the input transfer
  typedef struct packed {
    logic        valid;
    logic        by_player;
    logic [15:0] handle;
    logic [1:0]  player;
  } cst_lookup_t;

  // command held for the execute cycle, broadcast to every cell
  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] handle;
    logic [31:0] buttons;
    logic [15:0] stick_x;
    logic [15:0] stick_y;
    logic [7:0]  small_value;
  } cst_cmd_t;

  // slot contents as shown in a result, passed along the cell chain
  typedef struct packed {
    logic [1:0]  player;
    logic [15:0] handle;
    logic [31:0] buttons;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [7:0]  dpad;
    logic [7:0]  battery;
  } cst_view_t;

endpackage

[sv/cst_if.sv]
// ----------------------------------------------------------------------------
// cst_in_if / cst_out_if: valid-ready channels of the connection slot table
// A transfer happens at a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface cst_in_if;
  logic             valid;
  logic             ready;
  cst_pkg::cst_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cst_out_if;
  logic              valid;
  logic              ready;
  cst_pkg::cst_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/cst_cell.sv]
// ----------------------------------------------------------------------------
// cst_cell: one connection slot
// Holds one slot, registers its match against the incoming command, takes
// the claim token from its lower neighbor and ORs its contents onto the
// result bus when it is the first cell to claim the command.
// ----------------------------------------------------------------------------
module cst_cell #(
  parameter int unsigned PW = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cst_pkg::cst_lookup_t  lookup_i,
  input  cst_pkg::cst_cmd_t     cmd_i,
  input  logic [PW-1:0]         next_player_i,
  input  logic                  commit_i,
  input  logic                  take_i,
  input  cst_pkg::cst_view_t    view_i,
  output logic                  take_o,
  output cst_pkg::cst_view_t    view_o
);

  localparam int unsigned MW = (PW > 2) ? PW : 2;

  logic          active_q;
  logic [15:0]   handle_q,  handle_d;
  logic [PW-1:0] player_q,  player_d;
  logic [31:0]   buttons_q, buttons_d;
  logic [31:0]   left_q,    left_d;
  logic [31:0]   right_q,   right_d;
  logic [15:0]   dpbat_q,   dpbat_d;
  logic          active_d;
  logic          match_q;
  logic          free_q;
  logic          want;
  logic          hit;
  logic [MW-1:0] player_ext;
  logic [MW-1:0] query_ext;
  logic [PW+1:0] shown_player;
  cst_pkg::cst_view_t view;

  // compare this slot against the lookup key
  assign player_ext = MW'(player_q);
  assign query_ext  = MW'(lookup_i.player);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (lookup_i.valid) begin
      match_q <= active_q && (lookup_i.by_player ? (player_ext == query_ext)
                                                 : (handle_q == lookup_i.handle));
      free_q  <= !active_q;
    end
  end

  // claim the command if no lower cell has
  always_comb begin
    want = 1'b0;
    if (cmd_i.command == cst_pkg::CMD_ASSIGN) begin
      want = free_q;
    end else if (cmd_i.command >= cst_pkg::CMD_RELEASE &&
                 cmd_i.command <= cst_pkg::CMD_QUERY_PLAYER) begin
      want = match_q;
    end
  end

  assign hit    = want && !take_i;
  assign take_o = take_i || hit;

  // next slot contents for the claimed command
  always_comb begin
    active_d  = active_q;
    handle_d  = handle_q;
    player_d  = player_q;
    buttons_d = buttons_q;
    left_d    = left_q;
    right_d   = right_q;
    dpbat_d   = dpbat_q;
    case (cmd_i.command)
      cst_pkg::CMD_ASSIGN: begin
        active_d  = 1'b1;
        handle_d  = cmd_i.handle;
        player_d  = next_player_i;
        buttons_d = '0;
        left_d    = '0;
        right_d   = '0;
        dpbat_d   = '0;
      end
      cst_pkg::CMD_RELEASE: begin
        active_d  = 1'b0;
        handle_d  = '0;
        player_d  = '0;
        buttons_d = '0;
        left_d    = '0;
        right_d   = '0;
        dpbat_d   = '0;
      end
      cst_pkg::CMD_BUTTONS:     buttons_d = cmd_i.buttons;
      cst_pkg::CMD_LEFT_STICK:  left_d    = {cmd_i.stick_y, cmd_i.stick_x};
      cst_pkg::CMD_RIGHT_STICK: right_d   = {cmd_i.stick_y, cmd_i.stick_x};
      cst_pkg::CMD_DPAD:        dpbat_d   = {dpbat_q[15:8], cmd_i.small_value};
      cst_pkg::CMD_BATTERY:     dpbat_d   = {cmd_i.small_value, dpbat_q[7:0]};
      default: ;
    endcase
  end

  // update the slot when the command commits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      handle_q  <= '0;
      player_q  <= '0;
      buttons_q <= '0;
      left_q    <= '0;
      right_q   <= '0;
      dpbat_q   <= '0;
    end else if (commit_i && hit) begin
      active_q  <= active_d;
      handle_q  <= handle_d;
      player_q  <= player_d;
      buttons_q <= buttons_d;
      left_q    <= left_d;
      right_q   <= right_d;
      dpbat_q   <= dpbat_d;
    end
  end

  // show the slot after the command; a release shows it before clearing
  always_comb begin
    if (cmd_i.command == cst_pkg::CMD_RELEASE) begin
      shown_player = (PW + 2)'(player_q);
      view.handle  = handle_q;
      view.buttons = buttons_q;
      view.left_x  = left_q[15:0];
      view.left_y  = left_q[31:16];
      view.right_x = right_q[15:0];
      view.right_y = right_q[31:16];
      view.dpad    = dpbat_q[7:0];
      view.battery = dpbat_q[15:8];
    end else begin
      shown_player = (PW + 2)'(player_d);
      view.handle  = handle_d;
      view.buttons = buttons_d;
      view.left_x  = left_d[15:0];
      view.left_y  = left_d[31:16];
      view.right_x = right_d[15:0];
      view.right_y = right_d[31:16];
      view.dpad    = dpbat_d[7:0];
      view.battery = dpbat_d[15:8];
    end
    view.player = shown_player[1:0];
  end

  // merge onto the result bus
  assign view_o = hit ? (view_i | view) : view_i;

endmodule

[sv/connection_slot_table_top.sv]
// ----------------------------------------------------------------------------
// connection_slot_table_top: connection slot table keyed by handle
// A row of slot cells searched through a claim chain; assigns, releases,
// updates and queries slots one command at a time.
// ----------------------------------------------------------------------------
// Result path: the match register in each cell, then the claim chain into the
// result register; the execute step waits while an earlier result is not taken.
// A command executes before the next one is taken; the next command is taken
// while a result still waits to be transferred.
// Reset: asynchronous, clears every slot, the player counter and the count.
module connection_slot_table_top #(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cst_in_if.sink    req_i,
  cst_out_if.source rsp_o
);

  localparam int unsigned PW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam logic [PW-1:0] LAST_PLAYER = PW'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e               state_q, state_d;
  cst_pkg::cst_cmd_t    cmd_q;
  cst_pkg::cst_lookup_t lookup;
  logic [PW-1:0]        next_player_q, next_player_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW+2:0]        count_ext;
  logic                 accept;
  logic                 commit;
  logic                 found;
  logic [1:0]           status;
  logic                 rsp_valid_q;
  cst_pkg::cst_out_t    rsp_q;
  logic                 take [SLOT_COUNT+1];
  cst_pkg::cst_view_t   view [SLOT_COUNT+1];

  // handshake
  assign req_i.ready   = (state_q == S_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign commit        = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // sequence one command: accept, then execute
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // hold the command for the execute cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.command     <= req_i.payload.command;
      cmd_q.handle      <= req_i.payload.conn_handle;
      cmd_q.buttons     <= req_i.payload.button_bits;
      cmd_q.stick_x     <= req_i.payload.stick_x;
      cmd_q.stick_y     <= req_i.payload.stick_y;
      cmd_q.small_value <= req_i.payload.small_value;
    end
  end

  // lookup key for the cells
  assign lookup.valid     = accept;
  assign lookup.by_player = (req_i.payload.command == cst_pkg::CMD_QUERY_PLAYER);
  assign lookup.handle    = req_i.payload.conn_handle;
  assign lookup.player    = req_i.payload.player_query;

  // row of slot cells
  assign take[0] = 1'b0;
  assign view[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    cst_cell #(
      .PW (PW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .lookup_i      (lookup),
      .cmd_i         (cmd_q),
      .next_player_i (next_player_q),
      .commit_i      (commit),
      .take_i        (take[g]),
      .view_i        (view[g]),
      .take_o        (take[g+1]),
      .view_o        (view[g+1])
    );
  end

  assign found = take[SLOT_COUNT];

  // status, active count and player counter
  always_comb begin
    status        = cst_pkg::ST_OK;
    count_d       = count_q;
    next_player_d = next_player_q;
    if (cmd_q.command == cst_pkg::CMD_ASSIGN) begin
      if (!found) begin
        status = cst_pkg::ST_FULL;
      end else begin
        count_d       = count_q + CW'(1);
        next_player_d = (next_player_q == LAST_PLAYER) ? '0 : next_player_q + PW'(1);
      end
    end else if (cmd_q.command >= cst_pkg::CMD_RELEASE &&
                 cmd_q.command <= cst_pkg::CMD_QUERY_PLAYER) begin
      if (!found) begin
        status = cst_pkg::ST_NOT_FOUND;
      end else if (cmd_q.command == cst_pkg::CMD_RELEASE) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  assign count_ext = (CW + 3)'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      next_player_q <= '0;
    end else if (commit) begin
      count_q       <= count_d;
      next_player_q <= next_player_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_q.status        <= status;
      rsp_q.player_number <= view[SLOT_COUNT].player;
      rsp_q.active_count  <= count_ext[2:0];
      rsp_q.found_handle  <= view[SLOT_COUNT].handle;
      rsp_q.slot_buttons  <= view[SLOT_COUNT].buttons;
      rsp_q.left_x        <= view[SLOT_COUNT].left_x;
      rsp_q.left_y        <= view[SLOT_COUNT].left_y;
      rsp_q.right_x       <= view[SLOT_COUNT].right_x;
      rsp_q.right_y       <= view[SLOT_COUNT].right_y;
      rsp_q.dpad_code     <= view[SLOT_COUNT].dpad;
      rsp_q.battery_level <= view[SLOT_COUNT].battery;
    end
  end

endmodule
